FILE: src/rgb_mse_psnr_meter_macros.svh
// Assertion macros used by the port-level checker.
`ifndef RGB_MSE_PSNR_METER_MACROS_SVH
`define RGB_MSE_PSNR_METER_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define RMP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define RMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: src/rmp_pkg.sv
// Shared types and constants of the RGB MSE and PSNR meter.
package rmp_pkg;
   localparam int MAX_DIM_DEFAULT = 4096;
   localparam int CHANNEL_MAX_DEFAULT = 255;
   localparam int ACC_W = 42;
   localparam int CNT_W = 24;
   localparam int DIM_W = 13;
   localparam int MSE_W = 32;
   localparam int PSNR_W = 16;
   localparam int LOG_FRAC = 24;
   localparam int LOG_W = 30;
   localparam int QUO_W = 59;
   localparam logic [29:0] DB_PER_OCTAVE_Q28 = 30'd808071242;
   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accumulate;
      logic start_final;
      logic div_step;
      logic log_load;
      logic log_step;
      logic psnr_mult;
      logic psnr_done;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic region_end;
   } status_type;
endpackage

FILE: src/rmp_datapath.sv
// Datapath: accumulator, pixel counter, divider, log unit and result registers.
module rmp_datapath #(
   parameter int MAX_DIM = rmp_pkg::MAX_DIM_DEFAULT,
   parameter int CHANNEL_MAX = rmp_pkg::CHANNEL_MAX_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  rmp_pkg::cmd_type cmd,
   output rmp_pkg::status_type status,
   input  logic [rmp_pkg::DIM_W-1:0] region_width,
   input  logic [rmp_pkg::DIM_W-1:0] region_height,
   input  logic [7:0] first_red,
   input  logic [7:0] first_green,
   input  logic [7:0] first_blue,
   input  logic [7:0] second_red,
   input  logic [7:0] second_green,
   input  logic [7:0] second_blue,
   output logic [rmp_pkg::ACC_W-1:0] error_sum,
   output logic [rmp_pkg::MSE_W-1:0] mse_q16,
   output logic [rmp_pkg::PSNR_W-1:0] psnr_q8,
   output logic identical
);
   localparam int ACC_W = rmp_pkg::ACC_W;
   localparam int CNT_W = rmp_pkg::CNT_W;
   localparam int QW = rmp_pkg::QUO_W;
   localparam int LW = rmp_pkg::LOG_W;
   localparam int PSNR_W_L = rmp_pkg::PSNR_W;
   localparam logic [31:0] PEAK_SQ = 32'(CHANNEL_MAX * CHANNEL_MAX);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W:0] total;
   logic [CNT_W+1:0] denom_ff;
   logic [QW-1:0] num_ff, num_in;
   logic [CNT_W+2:0] rem_ff, rem_in;
   logic [63:0] x_ff;
   logic [ACC_W-1:0] sum_ff;
   logic [31:0] mx_ff, my_ff, mx_in, my_in;
   logic [LW-1:0] lx_ff, ly_ff, lx_in, ly_in;
   logic [LW-1:0] diff_ff;
   logic [59:0] prod_ff;
   logic [PSNR_W_L-1:0] psnr_sel;
   logic [rmp_pkg::MSE_W-1:0] mse_ff;
   logic [9:0] add_sum;
   logic [CNT_W+2:0] rem_shift;

   // Clamp a dimension register to 1..MAX_DIM.
   function automatic logic [CNT_W-1:0] clamp_dim(input logic [rmp_pkg::DIM_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = CNT_W'(v);
      if (v == '0) r = CNT_W'(1);
      else if (CNT_W'(v) > CNT_W'(MAX_DIM)) r = CNT_W'(MAX_DIM);
      return r;
   endfunction

   function automatic logic [8:0] sqd(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a >= b) ? a - b : b - a;
      return 9'(0) + 9'(d);
   endfunction

   // Integer part of log2 and normalized 32-bit mantissa.
   function automatic logic [37:0] norm(input logic [63:0] v);
      logic [5:0] top;
      logic [63:0] m;
      top = '0;
      for (int i = 0; i < 64; i++) if (v[i]) top = 6'(i);
      if (top > 6'd31) m = v >> (top - 6'd31);
      else m = v << (6'd31 - top);
      return {top, m[31:0]};
   endfunction

   // One fraction bit of the squaring log loop.
   function automatic logic [32:0] lstep(input logic [31:0] m);
      logic [63:0] p;
      logic [32:0] s;
      p = 64'(m) * 64'(m);
      s = p[63:31];
      if (s[32]) return {1'b1, s[32:1]};
      return {1'b0, s[31:0]};
   endfunction

   logic [8:0] dr, dg, db;
   logic [17:0] sq3;
   logic [32:0] sx, sy;
   logic [37:0] nx, ny;

   // The pixel total reaches 2^24, so it and the compare carry one extra bit.
   assign total = (CNT_W+1)'(clamp_dim(region_width) * clamp_dim(region_height));
   assign status.region_end = ({1'b0, cnt_ff} + (CNT_W+1)'(1)) >= total;
   assign dr = sqd(first_red, second_red);
   assign dg = sqd(first_green, second_green);
   assign db = sqd(first_blue, second_blue);
   assign sq3 = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
   assign add_sum = '0;
   assign rem_shift = {rem_ff[CNT_W+1:0], num_ff[QW-1]};
   assign sx = lstep(mx_ff);
   assign sy = lstep(my_ff);
   assign nx = norm(x_ff);
   assign ny = norm(64'(sum_ff));

   // Accumulator and pixel count.
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (cmd.accumulate) begin
         acc_in = acc_ff + ACC_W'(sq3) + ACC_W'(add_sum);
         cnt_in = status.region_end ? cnt_ff : cnt_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   // Restoring divider, one quotient bit per step.
   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      if (cmd.start_final) begin
         num_in = {1'b0, acc_in, 16'h0};
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, denom_ff}) begin
            rem_in = rem_shift - {1'b0, denom_ff};
            num_in = {num_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            num_in = {num_ff[QW-2:0], 1'b0};
         end
      end
   end

   // Log unit: both operands iterate together.
   always_comb begin
      mx_in = mx_ff;
      my_in = my_ff;
      lx_in = lx_ff;
      ly_in = ly_ff;
      if (cmd.log_load) begin
         mx_in = nx[31:0];
         my_in = ny[31:0];
         lx_in = {{(LW-6){1'b0}}, nx[37:32]};
         ly_in = {{(LW-6){1'b0}}, ny[37:32]};
      end else if (cmd.log_step) begin
         mx_in = sx[31:0];
         my_in = sy[31:0];
         lx_in = {lx_ff[LW-2:0], sx[32]};
         ly_in = {ly_ff[LW-2:0], sy[32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      lx_ff <= lx_in;
      ly_ff <= ly_in;
      if (cmd.start_final) begin
         sum_ff <= acc_in;
         denom_ff <= (CNT_W+2)'(total) * (CNT_W+2)'(3);
         x_ff <= 64'(PEAK_SQ) * 64'(total) * 64'(3);
      end
      // Log values are assembled integer part first, then shifted in.
      if (cmd.log_load) diff_ff <= '0;
      if (cmd.psnr_mult) begin
         diff_ff <= lx_ff - ly_ff;
         prod_ff <= '0;
      end
      if (cmd.psnr_done) begin
         prod_ff <= 60'(diff_ff) * 60'(rmp_pkg::DB_PER_OCTAVE_Q28);
      end
      if (cmd.clear) begin
         mse_ff <= num_ff[31:0];
      end
   end

   // Final PSNR selection; the scaled product always fits in 16 bits.
   always_comb begin
      if (sum_ff == '0) psnr_sel = '1;
      else if (lx_ff <= ly_ff) psnr_sel = '0;
      else psnr_sel = prod_ff[59:44];
   end

   assign error_sum = sum_ff;
   assign mse_q16 = mse_ff;
   assign psnr_q8 = psnr_sel;
   assign identical = (sum_ff == '0);
endmodule

FILE: src/rmp_ctrl.sv
// Controller: sequences accumulation, division, log and result hand-off.
module rmp_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  rmp_pkg::status_type status,
   output rmp_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      IDLE, DIVIDE, LOG_LOAD, LOG_RUN, MULT, PROD, CLEAR, RESP
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;

   assign take = req_valid && req_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      case (state_ff)
         IDLE: begin
            if (take) begin
               cmd.accumulate = 1'b1;
               if (status.region_end) begin
                  cmd.start_final = 1'b1;
                  state_in = DIVIDE;
                  step_in = '0;
               end
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(rmp_pkg::QUO_W - 1)) state_in = LOG_LOAD;
         end
         LOG_LOAD: begin
            cmd.log_load = 1'b1;
            step_in = '0;
            state_in = LOG_RUN;
         end
         LOG_RUN: begin
            cmd.log_step = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(rmp_pkg::LOG_FRAC - 1)) state_in = MULT;
         end
         MULT: begin
            cmd.psnr_mult = 1'b1;
            state_in = PROD;
         end
         PROD: begin
            cmd.psnr_done = 1'b1;
            state_in = CLEAR;
         end
         CLEAR: begin
            cmd.clear = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = RESP;
         end
         RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: src/rgb_mse_psnr_meter.sv
// Top level of the RGB MSE and PSNR meter.
// One pixel pair is taken per cycle while a region is open. The item that
// completes a region starts the final computation: a restoring divider of
// 59 steps, a log setup state, 24 log squaring steps, the multiply states
// MULT and PROD and a state that clears the accumulators, after which the
// result is valid and waits until taken; no pixel is accepted in that time,
// and input resumes the cycle after the result transaction. Zero-area or
// oversized dimensions clamp to 1 and MAX_DIM.
module rgb_mse_psnr_meter #(
   parameter int MAX_DIM = rmp_pkg::MAX_DIM_DEFAULT,
   parameter int CHANNEL_MAX = rmp_pkg::CHANNEL_MAX_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_first_red,
   input  logic [7:0] req_first_green,
   input  logic [7:0] req_first_blue,
   input  logic [7:0] req_second_red,
   input  logic [7:0] req_second_green,
   input  logic [7:0] req_second_blue,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [rmp_pkg::ACC_W-1:0] rsp_error_sum,
   output logic [rmp_pkg::MSE_W-1:0] rsp_mse_q16,
   output logic [rmp_pkg::PSNR_W-1:0] rsp_psnr_q8,
   output logic rsp_identical,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [rmp_pkg::DIM_W-1:0] csr_data
);
   rmp_pkg::cmd_type cmd;
   rmp_pkg::status_type status;
   logic [rmp_pkg::DIM_W-1:0] width_ff, height_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rmp_pkg::DIM_W'(64);
         height_ff <= rmp_pkg::DIM_W'(64);
      end else if (csr_write) begin
         if (csr_index == rmp_pkg::CSR_WIDTH) width_ff <= csr_data;
         if (csr_index == rmp_pkg::CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   rmp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   rmp_datapath #(.MAX_DIM(MAX_DIM), .CHANNEL_MAX(CHANNEL_MAX)) u_dp (
      .clock, .reset, .cmd, .status,
      .region_width(width_ff), .region_height(height_ff),
      .first_red(req_first_red), .first_green(req_first_green),
      .first_blue(req_first_blue), .second_red(req_second_red),
      .second_green(req_second_green), .second_blue(req_second_blue),
      .error_sum(rsp_error_sum), .mse_q16(rsp_mse_q16),
      .psnr_q8(rsp_psnr_q8), .identical(rsp_identical)
   );
endmodule

FILE: src/rmp_checker.sv
// Port-level checker of the meter, bound to the top level.
`include "rgb_mse_psnr_meter_macros.svh"
module rmp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [41:0] rsp_error_sum,
   input logic [15:0] rsp_psnr_q8,
   input logic rsp_identical
);
   `RMP_ASSERT_IMPL(a_no_take_while_resp, clock, reset, rsp_valid, !req_ready, "input taken during response")
   `RMP_ASSERT_IMPL(a_ident_sat, clock, reset, rsp_valid && rsp_identical, rsp_psnr_q8 == 16'hFFFF, "identical without saturated psnr")
   `RMP_ASSERT_IMPL(a_ident_zero, clock, reset, rsp_valid && rsp_identical, rsp_error_sum == 42'd0, "identical with nonzero sum")
   `RMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
endmodule

bind rgb_mse_psnr_meter rmp_checker u_rmp_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_error_sum, .rsp_psnr_q8, .rsp_identical
);

FILE: sim/testbench.sv
// Self-checking testbench of the RGB MSE and PSNR meter.
module testbench;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [rmp_pkg::ACC_W-1:0] error_sum;
      logic [rmp_pkg::MSE_W-1:0] mse_q16;
      logic [rmp_pkg::PSNR_W-1:0] psnr_q8;
      logic identical;
   } region_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [7:0] req_first_red;
   logic [7:0] req_first_green;
   logic [7:0] req_first_blue;
   logic [7:0] req_second_red;
   logic [7:0] req_second_green;
   logic [7:0] req_second_blue;
   logic rsp_valid;
   logic rsp_ready;
   logic [rmp_pkg::ACC_W-1:0] rsp_error_sum;
   logic [rmp_pkg::MSE_W-1:0] rsp_mse_q16;
   logic [rmp_pkg::PSNR_W-1:0] rsp_psnr_q8;
   logic rsp_identical;
   logic csr_write;
   logic csr_index;
   logic [rmp_pkg::DIM_W-1:0] csr_data;

   // Predictor state: configuration and running accumulation.
   logic [rmp_pkg::DIM_W-1:0] region_w;
   logic [rmp_pkg::DIM_W-1:0] region_h;
   logic [rmp_pkg::ACC_W-1:0] squared_error_total;
   logic [rmp_pkg::CNT_W-1:0] pixels_seen;
   region_result_type region_results_due[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int hold_len;
   int idle_streak;
   bit failed;

   rgb_mse_psnr_meter dut (.*);

   // Free-running clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // log2 of a value in Q.24 by repeated squaring of the mantissa.
   function automatic logic [63:0] log2_q24(input logic [63:0] v);
      int top;
      logic [63:0] m;
      logic [63:0] res;
      top = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) top = i;
      if (top > 31) m = v >> (top - 31);
      else m = v << (31 - top);
      m = {32'd0, m[31:0]};
      res = 64'(top) << rmp_pkg::LOG_FRAC;
      for (int i = rmp_pkg::LOG_FRAC - 1; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m[32]) begin
            res[i] = 1'b1;
            m = m >> 1;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] clamped_dim(input logic [rmp_pkg::DIM_W-1:0] v);
      if (v == 0) return 64'd1;
      if (v > rmp_pkg::MAX_DIM_DEFAULT) return 64'(rmp_pkg::MAX_DIM_DEFAULT);
      return 64'(v);
   endfunction

   function automatic logic [63:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [63:0] d;
      d = (a >= b) ? 64'(a - b) : 64'(b - a);
      return d * d;
   endfunction

   // Accumulates one accepted pixel pair and queues the region result at its end.
   task automatic predict_pixel();
      logic [63:0] total;
      logic [63:0] denom;
      logic [63:0] sum;
      logic [63:0] lx;
      logic [63:0] ly;
      logic [63:0] psnr;
      region_result_type r;
      squared_error_total = squared_error_total
         + rmp_pkg::ACC_W'(sq_diff(req_first_red, req_second_red)
         + sq_diff(req_first_green, req_second_green)
         + sq_diff(req_first_blue, req_second_blue));
      total = clamped_dim(region_w) * clamped_dim(region_h);
      if (64'(pixels_seen) + 1 < total) begin
         pixels_seen = pixels_seen + 1'b1;
         return;
      end
      sum = 64'(squared_error_total);
      denom = 3 * total;
      if (sum == 0) begin
         psnr = 64'd65535;
      end else begin
         lx = log2_q24(64'(rmp_pkg::CHANNEL_MAX_DEFAULT)
                       * 64'(rmp_pkg::CHANNEL_MAX_DEFAULT) * denom);
         ly = log2_q24(sum);
         if (lx <= ly) begin
            psnr = 0;
         end else begin
            psnr = ((lx - ly) * 64'(rmp_pkg::DB_PER_OCTAVE_Q28)) >> 44;
            if (psnr > 65535) psnr = 64'd65535;
         end
      end
      r.error_sum = squared_error_total;
      r.mse_q16 = rmp_pkg::MSE_W'((sum << 16) / denom);
      r.psnr_q8 = rmp_pkg::PSNR_W'(psnr);
      r.identical = (sum == 0);
      region_results_due.push_back(r);
      squared_error_total = '0;
      pixels_seen = '0;
   endtask

   // Offers one pixel pair and returns once the transaction is accepted.
   task automatic send_pixel(input logic [7:0] fr, input logic [7:0] fg,
                             input logic [7:0] fb, input logic [7:0] sr,
                             input logic [7:0] sg, input logic [7:0] sb);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(6, 1);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         if (gap > 1) @(negedge clock);
      end
      req_valid = 1'b1;
      req_first_red = fr;
      req_first_green = fg;
      req_first_blue = fb;
      req_second_red = sr;
      req_second_green = sg;
      req_second_blue = sb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel();
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Holds off until every queued result has arrived and the block is idle.
   task automatic wait_drained();
      stop_sending();
      while (region_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [rmp_pkg::DIM_W-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      if (index == rmp_pkg::CSR_WIDTH) region_w = value;
      else region_h = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_region(input logic [rmp_pkg::DIM_W-1:0] w,
                             input logic [rmp_pkg::DIM_W-1:0] h);
      write_reg(rmp_pkg::CSR_WIDTH, w);
      write_reg(rmp_pkg::CSR_HEIGHT, h);
   endtask

   // Sends one pixel pair whose content follows the given style.
   task automatic send_styled_pixel(input int style);
      logic [7:0] a [3];
      logic [7:0] b [3];
      for (int c = 0; c < 3; c++) begin
         a[c] = 8'($urandom);
         case (style)
            0: b[c] = a[c];
            1: b[c] = a[c] + 8'($urandom_range(4)) - 8'd2;
            2: b[c] = 8'($urandom);
            default: begin
               a[c] = $urandom_range(1) ? 8'hFF : 8'h00;
               b[c] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
         endcase
      end
      send_pixel(a[0], a[1], a[2], b[0], b[1], b[2]);
   endtask

   // One-pixel regions: identical pixels, the largest difference and single bits.
   task automatic test_single_pixel_regions();
      wait_drained();
      set_region(13'd0, 13'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
      for (int i = 0; i < 8; i++)
         send_pixel(8'd1 << i, 8'd0, 8'hFF, 8'd0, 8'd1 << i, 8'hFF ^ (8'd1 << i));
      wait_drained();
      set_region(13'd1, 13'd1);
      send_pixel(8'd10, 8'd20, 8'd30, 8'd11, 8'd20, 8'd30);
      send_pixel(8'd128, 8'd127, 8'd0, 8'd127, 8'd128, 8'd1);
      wait_drained();
   endtask

   // A region shrunk below the pixels already taken ends on the next pixel.
   task automatic test_shrink_midstream();
      set_region(13'd4, 13'd4);
      for (int i = 0; i < 10; i++) send_styled_pixel(2);
      wait_drained();
      set_region(13'd2, 13'd2);
      send_styled_pixel(2);
      send_styled_pixel(1);
      wait_drained();
   endtask

   // Largest widths and heights, including register values above the maximum.
   // Each large region stays open over a run of pixels and is then shrunk so
   // that the next pixel closes it.
   task automatic test_dimension_extremes();
      set_region(13'h1FFF, 13'd0);
      for (int i = 0; i < 30; i++) send_styled_pixel(3);
      wait_drained();
      set_region(13'd1, 13'd1);
      send_styled_pixel(3);
      wait_drained();
      set_region(13'd0, 13'd4096);
      for (int i = 0; i < 30; i++) send_styled_pixel(1);
      wait_drained();
      set_region(13'd1, 13'd1);
      send_styled_pixel(1);
      wait_drained();
      set_region(13'h1FFF, 13'h1FFF);
      for (int i = 0; i < 30; i++) send_styled_pixel(2);
      wait_drained();
      set_region(13'd1, 13'd1);
      send_styled_pixel(2);
      wait_drained();
   endtask

   // The receiver stalls for a long stretch while pixels keep coming.
   task automatic test_backpressure();
      set_region(13'd1, 13'd2);
      hold_len = 300;
      for (int i = 0; i < 12; i++) send_styled_pixel(2);
      wait_drained();
   endtask

   // Random regions of mostly small sizes under three idling schemes.
   task automatic test_random_regions();
      int sent;
      int w;
      int h;
      int style;
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 80 : 0;
         rsp_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 8 : 0;
         while (sent < 190 * (phase + 1)) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            h = $urandom_range(6, 1);
            style = $urandom_range(3);
            set_region(rmp_pkg::DIM_W'(w), rmp_pkg::DIM_W'(h));
            for (int i = 0; i < w * h; i++) send_styled_pixel(style);
            sent += w * h;
            if ($urandom_range(3) == 0) wait_drained();
            else begin
               stop_sending();
               while (region_results_due.size() != 0) @(posedge clock);
               repeat (DRAIN_CYCLES) @(posedge clock);
            end
         end
      end
   endtask

   // Receiver readiness, with a long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Result check and watchdog, both at the rising edge.
   always @(posedge clock) begin
      region_result_type r;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_streak = 0;
         else idle_streak++;
         if (rsp_valid && rsp_ready) begin
            if (region_results_due.size() == 0) begin
               $display("%0t: unexpected result, error_sum %0d", $time, rsp_error_sum);
               failed = 1'b1;
            end else begin
               r = region_results_due.pop_front();
               if (rsp_error_sum !== r.error_sum) begin
                  $display("%0t: error_sum expected %0d actual %0d",
                           $time, r.error_sum, rsp_error_sum);
                  failed = 1'b1;
               end
               if (rsp_mse_q16 !== r.mse_q16) begin
                  $display("%0t: mse_q16 expected %0d actual %0d",
                           $time, r.mse_q16, rsp_mse_q16);
                  failed = 1'b1;
               end
               if (rsp_psnr_q8 !== r.psnr_q8) begin
                  $display("%0t: psnr_q8 expected %0d actual %0d",
                           $time, r.psnr_q8, rsp_psnr_q8);
                  failed = 1'b1;
               end
               if (rsp_identical !== r.identical) begin
                  $display("%0t: identical expected %0d actual %0d",
                           $time, r.identical, rsp_identical);
                  failed = 1'b1;
               end
            end
         end
         if (idle_streak >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Reset, then the tests in turn, then the verdict.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_red = '0;
      req_first_green = '0;
      req_first_blue = '0;
      req_second_red = '0;
      req_second_green = '0;
      req_second_blue = '0;
      csr_write = 1'b0;
      csr_index = rmp_pkg::CSR_WIDTH;
      csr_data = '0;
      region_w = 13'd64;
      region_h = 13'd64;
      squared_error_total = '0;
      pixels_seen = '0;
      send_idle_pct = 8;
      rsp_idle_pct = 80;
      hold_len = 0;
      idle_streak = 0;
      failed = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_single_pixel_regions();
      test_shrink_midstream();
      test_backpressure();
      test_dimension_extremes();
      test_random_regions();
      wait_drained();
      if (!failed && region_results_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
